### hdl/dua_pkg.sv
// dedup uncertainty accumulator: shared types and constants
// item and result structs, sequencer states, bin map sizing
// no dependencies
`default_nettype none

package dua_pkg;

	localparam int BIN_COUNT = 256;

	// the 8-bit index cannot address more than 256 marks
	localparam int SEEN_DEPTH = (BIN_COUNT < 256) ? BIN_COUNT : 256;
	localparam int SEEN_AW    = $clog2(SEEN_DEPTH);

	localparam int SQ_W   = 56;
	localparam int ROOT_W = 28;
	localparam int PROD_W = 48;

	typedef struct packed {
		logic [7:0]  bin_index;
		logic [23:0] bin_yield;
		logic [23:0] stat_down;
		logic [23:0] stat_upward;
		logic [23:0] syst_down;
		logic [23:0] syst_upward;
	} in_item_t;

	typedef struct packed {
		logic        was_duplicate;
		logic [31:0] yield_total;
		logic [27:0] stat_down_total;
		logic [27:0] stat_up_total;
		logic [31:0] syst_down_total;
		logic [31:0] syst_up_total;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQ_DN,
		ST_SQ_UP,
		ST_SQ_ACC,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### hdl/dedup_uncertainty_accumulator.sv
// dedup uncertainty accumulator top level
// depends on dua_pkg for item types, states and bin map sizing
//
// usage: one item (bin index, yield, four uncertainties) enters on item /
// item_valid / item_stall, one result leaves on result / result_valid /
// result_stall for every item. an item is taken at a rising edge with
// valid high and stall low.
// a bin index already seen, or not below BIN_COUNT, is ignored and flagged
// in was_duplicate; the result then carries the unchanged totals and is
// registered from the output state, right after the check state.
// a new bin updates the linear sums, squares both statistical errors on
// one shared 24x24 multiplier (square-down and square-up states) and runs a
// restoring square root on both square sums, two bits of the sum per cycle;
// the result is registered from the output state once the root is done. in
// both cases the next item is taken only once the sequencer is back in idle.
// item_stall is high while an item is in work. a finished result sits in
// an output register, so the next item is taken while it waits; if the
// receiver stalls, the sequencer holds its next result until it drains.
// reset clears all bin marks, sums and roots at once, no clearing pass.
`default_nettype none

module dedup_uncertainty_accumulator
	import dua_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire in_item_t  item,
	output logic           result_valid,
	input  wire logic      result_stall,
	output out_item_t      result
);

	state_t state_q, state_d;

	in_item_t item_q;
	logic     dup_q;

	logic [SEEN_DEPTH-1:0] seen_q;

	logic [31:0]     yield_sum_q;
	logic [31:0]     syst_dn_sum_q;
	logic [31:0]     syst_up_sum_q;
	logic [SQ_W-1:0] sq_dn_q;
	logic [SQ_W-1:0] sq_up_q;
	logic [PROD_W-1:0] prod_q;

	logic [ROOT_W-1:0] root_dn_q;
	logic [ROOT_W-1:0] root_up_q;

	// shared root iteration registers, two lanes
	logic [SQ_W-1:0] rem_dn_q, rem_up_q;
	logic [SQ_W-1:0] res_dn_q, res_up_q;
	logic [SQ_W-1:0] bit_q;

	logic            result_valid_q;
	out_item_t       result_q;

	logic            in_range;
	logic            is_dup;
	logic [SEEN_AW-1:0] seen_idx;
	logic            out_free;
	logic [23:0]     mul_op;

	logic [SQ_W-1:0] trial_dn, trial_up;
	logic            ge_dn, ge_up;
	logic [SQ_W-1:0] rem_dn_nx, rem_up_nx;
	logic [SQ_W-1:0] res_dn_nx, res_up_nx;

	assign in_range = ({24'd0, item_q.bin_index} < 32'(BIN_COUNT));
	assign seen_idx = item_q.bin_index[SEEN_AW-1:0];
	assign is_dup   = !in_range || seen_q[seen_idx];
	assign out_free = !result_valid_q || !result_stall;
	assign mul_op   = (state_q == ST_SQ_DN) ? item_q.stat_down : item_q.stat_upward;

	always_comb begin
		trial_dn  = res_dn_q + bit_q;
		trial_up  = res_up_q + bit_q;
		ge_dn     = (rem_dn_q >= trial_dn);
		ge_up     = (rem_up_q >= trial_up);
		rem_dn_nx = ge_dn ? (rem_dn_q - trial_dn) : rem_dn_q;
		rem_up_nx = ge_up ? (rem_up_q - trial_up) : rem_up_q;
		res_dn_nx = ge_dn ? ((res_dn_q >> 1) + bit_q) : (res_dn_q >> 1);
		res_up_nx = ge_up ? ((res_up_q >> 1) + bit_q) : (res_up_q >> 1);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = is_dup ? ST_OUT : ST_SQ_DN;
			end
			ST_SQ_DN:     state_d = ST_SQ_UP;
			ST_SQ_UP:     state_d = ST_SQ_ACC;
			ST_SQ_ACC:    state_d = ST_ROOT_INIT;
			ST_ROOT_INIT: state_d = ST_ROOT;
			ST_ROOT: begin
				// last step works on the lowest bit
				if (bit_q[0]) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// item capture, multiplier and root iteration, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			item_q <= item;
		end
		if (state_q == ST_CHECK) begin
			dup_q <= is_dup;
		end
		if (state_q == ST_SQ_DN || state_q == ST_SQ_UP) begin
			prod_q <= PROD_W'(mul_op) * PROD_W'(mul_op);
		end
		if (state_q == ST_ROOT_INIT) begin
			rem_dn_q <= sq_dn_q;
			rem_up_q <= sq_up_q;
			res_dn_q <= '0;
			res_up_q <= '0;
			bit_q    <= SQ_W'(1) << (SQ_W - 2);
		end else if (state_q == ST_ROOT) begin
			rem_dn_q <= rem_dn_nx;
			rem_up_q <= rem_up_nx;
			res_dn_q <= res_dn_nx;
			res_up_q <= res_up_nx;
			bit_q    <= bit_q >> 2;
		end
	end

	// accumulated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= '0;
			yield_sum_q   <= '0;
			syst_dn_sum_q <= '0;
			syst_up_sum_q <= '0;
			sq_dn_q       <= '0;
			sq_up_q       <= '0;
			root_dn_q     <= '0;
			root_up_q     <= '0;
		end else begin
			if (state_q == ST_CHECK && !is_dup) begin
				seen_q[seen_idx] <= 1'b1;
				yield_sum_q      <= yield_sum_q + {8'd0, item_q.bin_yield};
				syst_dn_sum_q    <= syst_dn_sum_q + {8'd0, item_q.syst_down};
				syst_up_sum_q    <= syst_up_sum_q + {8'd0, item_q.syst_upward};
			end
			if (state_q == ST_SQ_UP) begin
				sq_dn_q <= sq_dn_q + {{(SQ_W - PROD_W){1'b0}}, prod_q};
			end
			if (state_q == ST_SQ_ACC) begin
				sq_up_q <= sq_up_q + {{(SQ_W - PROD_W){1'b0}}, prod_q};
			end
			if (state_q == ST_ROOT && bit_q[0]) begin
				root_dn_q <= res_dn_nx[ROOT_W-1:0];
				root_up_q <= res_up_nx[ROOT_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			result_q.was_duplicate   <= dup_q;
			result_q.yield_total     <= yield_sum_q;
			result_q.stat_down_total <= root_dn_q;
			result_q.stat_up_total   <= root_up_q;
			result_q.syst_down_total <= syst_dn_sum_q;
			result_q.syst_up_total   <= syst_up_sum_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### test/dedup_uncertainty_accumulator_tb.sv
// testbench for dedup_uncertainty_accumulator: bin items in, running totals out
// predicts seen-bin rejection, linear sums and quadrature roots; needs dua_pkg
`default_nettype none

module dedup_uncertainty_accumulator_tb;
	import dua_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 60;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	dedup_uncertainty_accumulator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// items waiting to be sent and totals waiting to come back
	in_item_t  bin_queue[$];
	out_item_t totals_due[$];

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int cycle_count;
	logic item_taken;

	// predictor state
	logic [SEEN_DEPTH-1:0] bins_seen;
	logic [31:0]           yield_acc;
	logic [SQ_W-1:0]       stat_dn_sq_acc;
	logic [SQ_W-1:0]       stat_up_sq_acc;
	logic [31:0]           syst_dn_acc;
	logic [31:0]           syst_up_acc;

	// generator bookkeeping, so fresh bins are spread over the run
	logic [255:0] bins_issued;
	int           bins_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [ROOT_W-1:0] floor_root(logic [SQ_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] t;
		logic [63:0]       sq;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			t = r | (ROOT_W'(1) << b);
			sq = 64'(t) * 64'(t);
			if (sq <= 64'(v))
				r = t;
		end
		return r;
	endfunction

	function automatic out_item_t accumulate_bin(in_item_t it);
		out_item_t o;
		logic      dup;
		dup = (int'(it.bin_index) >= BIN_COUNT) || bins_seen[it.bin_index];
		if (!dup) begin
			bins_seen[it.bin_index] = 1'b1;
			yield_acc      = yield_acc + 32'(it.bin_yield);
			stat_dn_sq_acc = stat_dn_sq_acc + SQ_W'(it.stat_down) * SQ_W'(it.stat_down);
			stat_up_sq_acc = stat_up_sq_acc + SQ_W'(it.stat_upward) * SQ_W'(it.stat_upward);
			syst_dn_acc    = syst_dn_acc + 32'(it.syst_down);
			syst_up_acc    = syst_up_acc + 32'(it.syst_upward);
		end
		o.was_duplicate   = dup;
		o.yield_total     = yield_acc;
		o.stat_down_total = floor_root(stat_dn_sq_acc);
		o.stat_up_total   = floor_root(stat_up_sq_acc);
		o.syst_down_total = syst_dn_acc;
		o.syst_up_total   = syst_up_acc;
		return o;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// driver: new item only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (bin_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item       <= bin_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: predict on every accepted item, check every accepted result
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= item_valid && !item_stall;
			if (item_valid && !item_stall)
				totals_due.push_back(accumulate_bin(item));
			if (result_valid && !result_stall) begin
				if (totals_due.size() == 0) begin
					$error("result with no item outstanding: %0h", result);
					error_count++;
				end else begin
					want = totals_due.pop_front();
					check_field("was_duplicate", 32'(want.was_duplicate),
						32'(result.was_duplicate));
					check_field("yield_total", want.yield_total, result.yield_total);
					check_field("stat_down_total", 32'(want.stat_down_total),
						32'(result.stat_down_total));
					check_field("stat_up_total", 32'(want.stat_up_total),
						32'(result.stat_up_total));
					check_field("syst_down_total", want.syst_down_total,
						result.syst_down_total);
					check_field("syst_up_total", want.syst_up_total, result.syst_up_total);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("dedup_uncertainty_accumulator_tb: FAIL");
		$finish;
	end

	function automatic logic [23:0] pick_value();
		case ($urandom_range(9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(255));
			3: return 24'hFFFFFF - 24'($urandom_range(255));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic in_item_t make_bin(logic [7:0] idx, logic [23:0] y, logic [23:0] sd,
		logic [23:0] su, logic [23:0] yd, logic [23:0] yu);
		in_item_t it;
		it.bin_index   = idx;
		it.bin_yield   = y;
		it.stat_down   = sd;
		it.stat_upward = su;
		it.syst_down   = yd;
		it.syst_upward = yu;
		if (!bins_issued[idx]) begin
			bins_issued[idx] = 1'b1;
			bins_left--;
		end
		return it;
	endfunction

	function automatic in_item_t random_bin();
		logic [7:0] idx;
		idx = 8'($urandom_range(255));
		// mostly repeats once the map fills; fresh bins about one item in six
		if (bins_left > 0 && $urandom_range(99) < 17) begin
			while (bins_issued[idx])
				idx = 8'($urandom_range(255));
		end
		return make_bin(idx, pick_value(), pick_value(), pick_value(), pick_value(),
			pick_value());
	endfunction

	task automatic wait_all_done();
		while (bin_queue.size() != 0 || item_valid || totals_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int n_items, int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n_items)
			bin_queue.push_back(random_bin());
		// the next phase waits until every total is back
		wait_all_done();
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		result_stall   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		bins_seen      = '0;
		yield_acc      = '0;
		stat_dn_sq_acc = '0;
		stat_up_sq_acc = '0;
		syst_dn_acc    = '0;
		syst_up_acc    = '0;
		bins_issued    = '0;
		bins_left      = 256;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty bin, all-max bins, repeats, single-field bins
		bin_queue.push_back(make_bin(8'd0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));
		bin_queue.push_back(make_bin(8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'hFFFFFF));
		bin_queue.push_back(make_bin(8'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'hFFFFFF));
		bin_queue.push_back(make_bin(8'd255, 24'h1, 24'h1, 24'h1, 24'h1, 24'h1));
		bin_queue.push_back(make_bin(8'd1, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0));
		bin_queue.push_back(make_bin(8'd2, 24'h0, 24'hFFFFFF, 24'h0, 24'h0, 24'h0));
		bin_queue.push_back(make_bin(8'd3, 24'h0, 24'h0, 24'hFFFFFF, 24'h0, 24'h0));
		bin_queue.push_back(make_bin(8'd4, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'h0));
		bin_queue.push_back(make_bin(8'd5, 24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF));
		bin_queue.push_back(make_bin(8'd128, 24'h1, 24'h1, 24'h1, 24'h1, 24'h1));
		bin_queue.push_back(make_bin(8'd127, 24'h100, 24'h3, 24'h4, 24'h100, 24'h100));
		bin_queue.push_back(make_bin(8'd170, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
			24'h555555, 24'hAAAAAA));
		bin_queue.push_back(make_bin(8'd85, 24'h555555, 24'hAAAAAA, 24'h555555,
			24'hAAAAAA, 24'h555555));
		bin_queue.push_back(make_bin(8'd128, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'hFFFFFF));
		bin_queue.push_back(make_bin(8'd1, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));
		wait_all_done();

		run_phase(360, 0, 0);
		run_phase(360, 55, 0);
		run_phase(360, 0, 55);
		run_phase(360, 23, 23);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("dedup_uncertainty_accumulator_tb: PASS");
		else
			$display("dedup_uncertainty_accumulator_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### dedup_uncertainty_accumulator.f
hdl/dua_pkg.sv
hdl/dedup_uncertainty_accumulator.sv
test/dedup_uncertainty_accumulator_tb.sv
